// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds on every clock outside of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/daf_pkg.sv =====
package daf_pkg;

  localparam int DAF_VALUE_BITS_DEF = 64;
  localparam int DAF_VALUE_W        = 64;
  localparam int DAF_SIZE_W         = 8;
  localparam int DAF_POS_W          = 8;
  localparam int DAF_CHAR_W         = 8;
  localparam int DAF_LEN_W          = 5;
  localparam int DAF_BCD_W          = 4;
  // decimal digits for a 64-bit value
  localparam int DAF_NDIG_DEF       = 20;

  localparam int DAF_PREFIX_LEN     = 10;
  localparam logic [DAF_CHAR_W-1:0] DAF_ASCII_ZERO = 8'h30;
  localparam logic [DAF_CHAR_W-1:0] DAF_TERM       = 8'h00;

  // ten-byte tag written ahead of the number
  localparam logic [DAF_CHAR_W-1:0] DAF_PREFIX [0:DAF_PREFIX_LEN-1] = '{
    8'h77, 8'h61, 8'h69, 8'h74, 8'h5F, 8'h70, 8'h6F, 8'h72, 8'h74, 8'h5F
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,     // double-dabble, one value bit per cycle
    S_NORM,     // drop leading zero digits
    S_PREFIX,
    S_DIGITS,
    S_TERM,
    S_FAILMID,  // terminator after prefix when number does not fit
    S_FAIL0,    // lone terminator at offset 0
    S_NONE      // zero-size buffer, no write
  } daf_state_t;

  typedef struct packed {
    logic clear;
    logic bit_shift;
    logic dig_shift;
  } daf_cell_ctrl_t;

endpackage

// ===== hdl/daf_in_if.sv =====
interface daf_in_if import daf_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [DAF_VALUE_W-1:0] value;
  logic [DAF_SIZE_W-1:0]  buffer_size;

  modport source (output valid, op, value, buffer_size, input ready);
  modport sink   (input valid, op, value, buffer_size, output ready);
endinterface

// ===== hdl/daf_out_if.sv =====
interface daf_out_if import daf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  write_valid;
  logic [DAF_POS_W-1:0]  write_position;
  logic [DAF_CHAR_W-1:0] char_code;
  logic                  last;
  logic [DAF_LEN_W-1:0]  length;

  modport source (output valid, write_valid, write_position, char_code, last, length,
                  input ready);
  modport sink   (input valid, write_valid, write_position, char_code, last, length,
                  output ready);
endinterface

// ===== hdl/decimal_ascii_formatter_unit.sv =====
// Each item goes through bit-serial conversion in the BCD chain, leading-zero stripping
// and then its writes; a new item is taken only once the sequencer is back in idle.
// One output word per cycle while the sink is ready; up to 31 words per item.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the
// output register; digit cells are cleared when an item is taken.
module decimal_ascii_formatter_unit import daf_pkg::*; #(
  parameter int VALUE_BITS = DAF_VALUE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  daf_in_if.sink   in_ch,
  daf_out_if.source out_ch
);

  `include "assert_macros.svh"

  // decimal digits needed for VALUE_BITS: ceil(VALUE_BITS * log10(2))
  localparam int NDIG = (VALUE_BITS * 30103 + 99999) / 100000;
  localparam int NDW  = $clog2(NDIG + 1);
  localparam int BCW  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int PW   = DAF_LEN_W;   // positions stay below 31

  daf_state_t state_r, state_nxt;

  logic                  op_r;
  logic [DAF_SIZE_W-1:0] size_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [BCW-1:0]        bit_cnt_r;
  logic [NDW-1:0]        ndig_r;
  logic [PW-1:0]         pos_r;

  // output register
  logic                  out_valid_r;
  logic                  w_valid_r;
  logic [PW-1:0]         w_pos_r;
  logic [DAF_CHAR_W-1:0] w_char_r;
  logic                  w_last_r;
  logic [DAF_LEN_W-1:0]  w_len_r;

  // word being formed this cycle
  logic                  emit;
  logic                  w_valid;
  logic [PW-1:0]         w_pos;
  logic [DAF_CHAR_W-1:0] w_char;
  logic                  w_last;
  logic [DAF_LEN_W-1:0]  w_len;

  daf_cell_ctrl_t        ctrl;
  logic [DAF_BCD_W-1:0]  top_digit;
  logic                  chain_ovf;

  logic in_take, load, strip, conv_done;
  logic fit_plain, fit_after_prefix, prefix_short, prefix_end;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  // output slot free, or its word leaves this cycle
  assign load        = !out_valid_r || out_ch.ready;
  assign conv_done   = (bit_cnt_r == '0);
  assign strip       = (state_r == S_NORM) && (top_digit == '0) && (ndig_r > NDW'(1));

  // digits plus terminator must fit the window
  assign fit_plain        = (9'(ndig_r) + 9'd1) <= 9'(size_r);
  assign fit_after_prefix = (9'(ndig_r) + 9'(DAF_PREFIX_LEN + 1)) <= 9'(size_r);
  assign prefix_short     = size_r < DAF_SIZE_W'(DAF_PREFIX_LEN + 1);
  assign prefix_end       = (pos_r == PW'(DAF_PREFIX_LEN - 1));

  daf_bcd_chain #(.NDIG(NDIG)) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .ser_in    (value_r[VALUE_BITS-1]),
    .top_digit (top_digit),
    .overflow  (chain_ovf)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (conv_done) state_nxt = S_NORM;
      end
      S_NORM: begin
        if (!strip) begin
          if (size_r == '0) begin
            state_nxt = S_NONE;
          end else if (!op_r) begin
            state_nxt = fit_plain ? S_DIGITS : S_FAIL0;
          end else begin
            state_nxt = prefix_short ? S_FAIL0 : S_PREFIX;
          end
        end
      end
      S_PREFIX: begin
        if (load && prefix_end) state_nxt = fit_after_prefix ? S_DIGITS : S_FAILMID;
      end
      S_DIGITS: begin
        if (load && ndig_r == NDW'(1)) state_nxt = S_TERM;
      end
      S_FAILMID: begin
        if (load) state_nxt = S_FAIL0;
      end
      S_TERM, S_FAIL0, S_NONE: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    emit           = 1'b0;
    w_valid        = 1'b1;
    w_pos          = pos_r;
    w_char         = DAF_TERM;
    w_last         = 1'b0;
    w_len          = '0;
    ctrl.clear     = 1'b0;
    ctrl.bit_shift = 1'b0;
    ctrl.dig_shift = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctrl.clear = in_take;
      end
      S_CONV: begin
        ctrl.bit_shift = 1'b1;
      end
      S_NORM: begin
        ctrl.dig_shift = strip;
      end
      S_PREFIX: begin
        emit   = 1'b1;
        w_char = DAF_PREFIX[pos_r[3:0]];
      end
      S_DIGITS: begin
        emit           = 1'b1;
        w_char         = DAF_ASCII_ZERO | DAF_CHAR_W'(top_digit);
        ctrl.dig_shift = load;
      end
      S_TERM: begin
        // terminator offset equals the returned length
        emit   = 1'b1;
        w_last = 1'b1;
        w_len  = DAF_LEN_W'(pos_r);
      end
      S_FAILMID: begin
        emit = 1'b1;
      end
      S_FAIL0: begin
        emit   = 1'b1;
        w_pos  = '0;
        w_last = 1'b1;
      end
      S_NONE: begin
        emit    = 1'b1;
        w_valid = 1'b0;
        w_pos   = '0;
        w_last  = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit && load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r      <= in_ch.op;
      size_r    <= in_ch.buffer_size;
      value_r   <= in_ch.value[VALUE_BITS-1:0];
      bit_cnt_r <= BCW'(VALUE_BITS - 1);
    end
    if (state_r == S_CONV) begin
      value_r   <= value_r << 1;
      bit_cnt_r <= bit_cnt_r - BCW'(1);
      if (conv_done) begin
        ndig_r <= NDW'(NDIG);
        pos_r  <= '0;
      end
    end
    if (strip) ndig_r <= ndig_r - NDW'(1);
    if (state_r == S_PREFIX && load) pos_r <= pos_r + PW'(1);
    if (state_r == S_DIGITS && load) begin
      pos_r  <= pos_r + PW'(1);
      ndig_r <= ndig_r - NDW'(1);
    end
    if (emit && load) begin
      w_valid_r <= w_valid;
      w_pos_r   <= w_pos;
      w_char_r  <= w_char;
      w_last_r  <= w_last;
      w_len_r   <= w_len;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.write_valid    = w_valid_r;
  assign out_ch.write_position = DAF_POS_W'(w_pos_r);
  assign out_ch.char_code      = w_char_r;
  assign out_ch.last           = w_last_r;
  assign out_ch.length         = w_len_r;

  // ---------------- assertions ----------------
  // the digit chain is sized so conversion never carries out of the top cell
  `ASSERT_IMPLIES(a_chain_no_ovf, clk, rst_n, ctrl.bit_shift, !chain_ovf, "BCD chain overflow")
  // a nonzero length is reported only with the terminator at that offset
  `ASSERT_IMPLIES(a_len_is_pos, clk, rst_n,
    out_ch.valid && out_ch.last && out_ch.length != '0,
    out_ch.write_position == DAF_POS_W'(out_ch.length) && out_ch.char_code == DAF_TERM,
    "length does not match terminator")
  // digit emission never runs past the counted digits
  `ASSERT_IMPLIES(a_digits_left, clk, rst_n, state_r == S_DIGITS, ndig_r != '0, "digit count underflow")

endmodule

// ===== hdl/daf_bcd_cell.sv =====
module daf_bcd_cell import daf_pkg::*; (
  input  logic                 clk,
  input  daf_cell_ctrl_t       ctrl,
  input  logic                 carry_in,
  input  logic [DAF_BCD_W-1:0] dig_in,
  output logic [DAF_BCD_W-1:0] digit,
  output logic                 carry_out
);

  logic [DAF_BCD_W-1:0] digit_r;
  logic [DAF_BCD_W-1:0] adj;

  // add 3 when >= 5 so the following doubling carries correctly
  assign adj       = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign carry_out = adj[DAF_BCD_W-1];
  assign digit     = digit_r;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit_r <= '0;
    end else if (ctrl.bit_shift) begin
      digit_r <= {adj[DAF_BCD_W-2:0], carry_in};
    end else if (ctrl.dig_shift) begin
      digit_r <= dig_in;
    end
  end

endmodule

// ===== hdl/daf_bcd_chain.sv =====
module daf_bcd_chain import daf_pkg::*; #(
  parameter int NDIG = DAF_NDIG_DEF
) (
  input  logic                 clk,
  input  daf_cell_ctrl_t       ctrl,
  input  logic                 ser_in,
  output logic [DAF_BCD_W-1:0] top_digit,
  output logic                 overflow
);

  logic [DAF_BCD_W-1:0] digits [0:NDIG-1];
  logic                 carry  [0:NDIG-1];

  // cell 0 is the least significant digit
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == 0) begin : g_lsd
      daf_bcd_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (ser_in),
        .dig_in    ('0),
        .digit     (digits[i]),
        .carry_out (carry[i])
      );
    end else begin : g_upper
      daf_bcd_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[i-1]),
        .dig_in    (digits[i-1]),
        .digit     (digits[i]),
        .carry_out (carry[i])
      );
    end
  end

  assign top_digit = digits[NDIG-1];
  assign overflow  = carry[NDIG-1];

endmodule
